[rtl/core/sequence_read_quality_filter_assert.svh]
// ----------------------------------------------------------------------------
// Read quality filter assertion macros
// Shared concurrent assertion forms used by the read quality filter RTL.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_READ_QUALITY_FILTER_ASSERT_SVH
`define SEQUENCE_READ_QUALITY_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SQRF_ASSERT_IMPLY(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SQRF_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[rtl/core/sqrf_pkg.sv]
// ----------------------------------------------------------------------------
// Read quality filter package
// Widths, register indexes, reset values and constants of the filter.
// ----------------------------------------------------------------------------
package sqrf_pkg;

    localparam int MAX_READ_LENGTH_DEFAULT = 1024;

    localparam int CFG_DATA_W  = 17;
    localparam int CFG_INDEX_W = 3;

    localparam int CHAR_W      = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int COUNTER_W   = 32;
    localparam int OUT_TDATA_W = 168;

    localparam int OFFSET_W    = 7;
    localparam int MIN_BQ_W    = 7;
    localparam int RATE_W      = 17;
    localparam int MEAN_Q_W    = 15;
    localparam int MEAN_THR_W  = 16;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_QUALITY_OFFSET   = 3'd0,
        CFG_LOW_Q_MARGIN     = 3'd1,
        CFG_MAX_N_RATE       = 3'd2,
        CFG_MIN_MEAN_QUALITY = 3'd3,
        CFG_MAX_LOW_RATE     = 3'd4
    } t_cfg_index;

    localparam logic [OFFSET_W-1:0] RST_QUALITY_OFFSET   = 7'd33;
    localparam logic [MIN_BQ_W-1:0] RST_LOW_Q_MARGIN     = 7'd5;
    localparam logic [RATE_W-1:0]   RST_MAX_N_RATE       = 17'd6554;
    localparam logic [MEAN_Q_W-1:0] RST_MIN_MEAN_QUALITY = 15'd0;
    localparam logic [RATE_W-1:0]   RST_MAX_LOW_RATE     = 17'd32768;

    // Character code of an unknown base.
    localparam logic [CHAR_W-1:0] UNKNOWN_BASE = 8'd78;

endpackage

[rtl/core/sequence_read_quality_filter.sv]
// A closing base passes through the input register, and its verdict is then loaded into
// the result register, from which it is offered on the result stream.
// Throughput: one base per cycle, with no gap between reads, set by the
// accumulate-and-compare stage; a closing base waits only while an earlier result is held.
// Reset (synchronous, active low) restores the register defaults, clears the per-read
// accumulators and all running counters, and empties both register stages.
// ----------------------------------------------------------------------------
// Read quality filter
// Accumulates per-read statistics over a base stream and, on the last base of
// each read, checks the N rate, mean quality and low-quality rate against the
// programmed thresholds, reporting the verdict with running counters.
// ----------------------------------------------------------------------------
`include "sequence_read_quality_filter_assert.svh"

module sequence_read_quality_filter #(
    parameter int MAX_READ_LENGTH = sqrf_pkg::MAX_READ_LENGTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [sqrf_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [sqrf_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // Base stream: tdata holds base_char [7:0], quality_char [15:8];
    // tlast is read_end.
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sqrf_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                s_axis_tlast,
    // Result stream: tdata holds dropped [0], n_rate_fail [1],
    // mean_quality_fail [2], low_rate_fail [3], reads_total [35:4],
    // reads_dropped [67:36], reads_n_fail [99:68], reads_mean_fail [131:100],
    // reads_low_fail [163:132], zero padding [167:164].
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [sqrf_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

    // Width of the per-read base counters: must hold MAX_READ_LENGTH itself.
    localparam int LEN_W  = $clog2(MAX_READ_LENGTH + 1);
    // Quality sum over at most MAX_READ_LENGTH characters of 8 bits.
    localparam int SUM_W  = LEN_W + sqrf_pkg::CHAR_W;
    // Rate products: a Q1.16 threshold times the read length.
    localparam int RPROD_W = LEN_W + sqrf_pkg::RATE_W;
    // Mean products: a Q8.8 threshold times the read length.
    localparam int MPROD_W = LEN_W + sqrf_pkg::MEAN_THR_W;
    localparam int CW      = sqrf_pkg::COUNTER_W;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_READ_LENGTH);

    // ------------------------------------------------------------------
    // Configuration registers. They must only be written by the user while the
    // filter is idle; the block does not enforce this, so the compare stage may read them directly.
    // ------------------------------------------------------------------
    logic [sqrf_pkg::OFFSET_W-1:0] r_quality_offset;
    logic [sqrf_pkg::MIN_BQ_W-1:0] r_low_q_margin;
    logic [sqrf_pkg::RATE_W-1:0]   r_max_n_rate;
    logic [sqrf_pkg::MEAN_Q_W-1:0] r_min_mean_quality;
    logic [sqrf_pkg::RATE_W-1:0]   r_max_low_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quality_offset   <= sqrf_pkg::RST_QUALITY_OFFSET;
            r_low_q_margin     <= sqrf_pkg::RST_LOW_Q_MARGIN;
            r_max_n_rate       <= sqrf_pkg::RST_MAX_N_RATE;
            r_min_mean_quality <= sqrf_pkg::RST_MIN_MEAN_QUALITY;
            r_max_low_rate     <= sqrf_pkg::RST_MAX_LOW_RATE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                sqrf_pkg::CFG_QUALITY_OFFSET: begin
                    r_quality_offset <= i_cfg_wdata[sqrf_pkg::OFFSET_W-1:0];
                end
                sqrf_pkg::CFG_LOW_Q_MARGIN: begin
                    r_low_q_margin <= i_cfg_wdata[sqrf_pkg::MIN_BQ_W-1:0];
                end
                sqrf_pkg::CFG_MAX_N_RATE: begin
                    r_max_n_rate <= i_cfg_wdata[sqrf_pkg::RATE_W-1:0];
                end
                sqrf_pkg::CFG_MIN_MEAN_QUALITY: begin
                    r_min_mean_quality <= i_cfg_wdata[sqrf_pkg::MEAN_Q_W-1:0];
                end
                sqrf_pkg::CFG_MAX_LOW_RATE: begin
                    r_max_low_rate <= i_cfg_wdata[sqrf_pkg::RATE_W-1:0];
                end
                default: begin
                    // Indexes beyond the register list are ignored.
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. A base is held here before it reaches the accumulators.
    // An ordinary base always moves on; only a closing base waits, and only
    // while the result register is still occupied.
    // ------------------------------------------------------------------
    logic                          r_in_valid;
    logic [sqrf_pkg::CHAR_W-1:0]   r_in_base;
    logic [sqrf_pkg::CHAR_W-1:0]   r_in_qual;
    logic                          r_in_last;

    logic out_free;
    logic consume;

    assign out_free      = !m_axis_tvalid || m_axis_tready;
    assign consume       = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || consume;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_base <= s_axis_tdata[sqrf_pkg::CHAR_W-1:0];
            r_in_qual <= s_axis_tdata[2*sqrf_pkg::CHAR_W-1:sqrf_pkg::CHAR_W];
            r_in_last <= s_axis_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Per-read accumulators. Once a read reaches the length limit further
    // bases are ignored, though their end flag still closes the read.
    // ------------------------------------------------------------------
    logic [LEN_W-1:0] r_base_count, n_base_count;
    logic [LEN_W-1:0] r_unknown_count, n_unknown_count;
    logic [SUM_W-1:0] r_quality_sum, n_quality_sum;
    logic [LEN_W-1:0] r_low_count, n_low_count;

    logic                        acc_en;
    logic [sqrf_pkg::CHAR_W-1:0] low_limit;
    logic                        is_unknown;
    logic                        is_low;

    always_comb begin
        acc_en     = r_base_count < LEN_MAX;
        // Both terms are 7 bits, so their sum fits in a character.
        low_limit  = sqrf_pkg::CHAR_W'(r_quality_offset) +
                     sqrf_pkg::CHAR_W'(r_low_q_margin);
        is_unknown = r_in_base == sqrf_pkg::UNKNOWN_BASE;
        is_low     = r_in_qual < low_limit;

        n_base_count    = r_base_count;
        n_unknown_count = r_unknown_count;
        n_quality_sum   = r_quality_sum;
        n_low_count     = r_low_count;
        if (acc_en) begin
            n_base_count  = r_base_count + LEN_W'(1);
            n_quality_sum = r_quality_sum + SUM_W'(r_in_qual);
            if (is_unknown) begin
                n_unknown_count = r_unknown_count + LEN_W'(1);
            end
            if (is_low) begin
                n_low_count = r_low_count + LEN_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Read verdict. Each rate rule compares count * 2^16 against
    // threshold * length, and the mean rule compares sum * 2^8 against
    // (offset * 2^8 + minimum mean) * length, so no division is needed.
    // The three products are independent and each is at most 17 x 11 bits.
    // A rate threshold above one can never be exceeded by construction.
    // ------------------------------------------------------------------
    logic [sqrf_pkg::MEAN_THR_W-1:0] mean_thr;
    logic [RPROD_W-1:0]              n_limit;
    logic [RPROD_W-1:0]              low_limit_prod;
    logic [MPROD_W-1:0]              mean_limit;
    logic [RPROD_W-1:0]              n_scaled;
    logic [RPROD_W-1:0]              low_scaled;
    logic [MPROD_W-1:0]              sum_scaled;
    logic                            n_fail;
    logic                            mean_fail;
    logic                            low_fail;
    logic                            drop;

    always_comb begin
        mean_thr       = {1'b0, r_quality_offset, 8'd0} +
                         sqrf_pkg::MEAN_THR_W'(r_min_mean_quality);
        n_limit        = RPROD_W'(r_max_n_rate) * RPROD_W'(n_base_count);
        low_limit_prod = RPROD_W'(r_max_low_rate) * RPROD_W'(n_base_count);
        mean_limit     = MPROD_W'(mean_thr) * MPROD_W'(n_base_count);
        n_scaled       = {1'b0, n_unknown_count, 16'd0};
        low_scaled     = {1'b0, n_low_count, 16'd0};
        sum_scaled     = {n_quality_sum, 8'd0};
        n_fail         = n_scaled > n_limit;
        low_fail       = low_scaled > low_limit_prod;
        mean_fail      = sum_scaled < mean_limit;
        drop           = n_fail || mean_fail || low_fail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_count    <= '0;
            r_unknown_count <= '0;
            r_quality_sum   <= '0;
            r_low_count     <= '0;
        end else if (consume) begin
            if (r_in_last) begin
                r_base_count    <= '0;
                r_unknown_count <= '0;
                r_quality_sum   <= '0;
                r_low_count     <= '0;
            end else begin
                r_base_count    <= n_base_count;
                r_unknown_count <= n_unknown_count;
                r_quality_sum   <= n_quality_sum;
                r_low_count     <= n_low_count;
            end
        end
    end

    // ------------------------------------------------------------------
    // Running counters. They wrap and advance only when a read closes.
    // ------------------------------------------------------------------
    logic [CW-1:0] r_total_cnt,   n_total_cnt;
    logic [CW-1:0] r_dropped_cnt, n_dropped_cnt;
    logic [CW-1:0] r_n_fail_cnt,  n_n_fail_cnt;
    logic [CW-1:0] r_mean_fail_cnt, n_mean_fail_cnt;
    logic [CW-1:0] r_low_fail_cnt,  n_low_fail_cnt;

    always_comb begin
        n_total_cnt     = r_total_cnt + CW'(1);
        n_dropped_cnt   = r_dropped_cnt + CW'(drop);
        n_n_fail_cnt    = r_n_fail_cnt + CW'(n_fail);
        n_mean_fail_cnt = r_mean_fail_cnt + CW'(mean_fail);
        n_low_fail_cnt  = r_low_fail_cnt + CW'(low_fail);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_cnt     <= '0;
            r_dropped_cnt   <= '0;
            r_n_fail_cnt    <= '0;
            r_mean_fail_cnt <= '0;
            r_low_fail_cnt  <= '0;
        end else if (consume && r_in_last) begin
            r_total_cnt     <= n_total_cnt;
            r_dropped_cnt   <= n_dropped_cnt;
            r_n_fail_cnt    <= n_n_fail_cnt;
            r_mean_fail_cnt <= n_mean_fail_cnt;
            r_low_fail_cnt  <= n_low_fail_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Result register. It keeps its own copy of the counters so that a
    // stalled result transfer is unaffected by later reads.
    // ------------------------------------------------------------------
    logic          r_out_valid;
    logic          r_out_drop;
    logic          r_out_n_fail;
    logic          r_out_mean_fail;
    logic          r_out_low_fail;
    logic [CW-1:0] r_out_total;
    logic [CW-1:0] r_out_dropped;
    logic [CW-1:0] r_out_n_cnt;
    logic [CW-1:0] r_out_mean_cnt;
    logic [CW-1:0] r_out_low_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (consume && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (consume && r_in_last) begin
            r_out_drop      <= drop;
            r_out_n_fail    <= n_fail;
            r_out_mean_fail <= mean_fail;
            r_out_low_fail  <= low_fail;
            r_out_total     <= n_total_cnt;
            r_out_dropped   <= n_dropped_cnt;
            r_out_n_cnt     <= n_n_fail_cnt;
            r_out_mean_cnt  <= n_mean_fail_cnt;
            r_out_low_cnt   <= n_low_fail_cnt;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out_low_cnt, r_out_mean_cnt, r_out_n_cnt,
                            r_out_dropped, r_out_total, r_out_low_fail,
                            r_out_mean_fail, r_out_n_fail, r_out_drop};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `SQRF_ASSERT_IMPLY(a_len_bounded, i_clk, i_rst_n, 1'b1, r_base_count <= LEN_MAX, "base count above the read length limit")
    `SQRF_ASSERT_NEXT(a_close_clears, i_clk, i_rst_n, consume && r_in_last, r_base_count == '0 && r_low_count == '0, "accumulators not cleared after a closing base")
    `SQRF_ASSERT_NEXT(a_result_counts, i_clk, i_rst_n, consume && r_in_last, r_out_valid && r_out_total == r_total_cnt, "result total does not match the running counter")
    `SQRF_ASSERT_NEXT(a_mid_read_quiet, i_clk, i_rst_n, !(consume && r_in_last), $stable(r_total_cnt), "running counter moved without a closing base")

endmodule

[tb/sv/read_verdict_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read verdict checker
// Watches the configuration port and both streams of the read quality filter,
// predicts the verdict and counters of every closed read and compares each
// result transfer with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module read_verdict_checker #(
    parameter int MAX_READ_LENGTH = sqrf_pkg::MAX_READ_LENGTH_DEFAULT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [sqrf_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [sqrf_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    // Base stream: tdata holds base_char [7:0], quality_char [15:8].
    input  logic                             i_base_tvalid,
    input  logic                             i_base_tready,
    input  logic [sqrf_pkg::IN_TDATA_W-1:0]  i_base_tdata,
    input  logic                             i_base_tlast,
    // Result stream: tdata holds dropped, n_rate_fail, mean_quality_fail,
    // low_rate_fail, then the five 32-bit counters from reads_total up.
    input  logic                             i_verdict_tvalid,
    input  logic                             i_verdict_tready,
    input  logic [sqrf_pkg::OUT_TDATA_W-1:0] i_verdict_tdata,
    output int                               o_pending,
    output int                               o_fail_count
);

    localparam int LEN_W = $clog2(MAX_READ_LENGTH + 1);
    localparam int SUM_W = $clog2(MAX_READ_LENGTH * 255 + 1);
    localparam int CNT_W = sqrf_pkg::COUNTER_W;
    localparam int CHR_W = sqrf_pkg::CHAR_W;

    // Listed from the top bit down, so dropped lands in bit 0.
    typedef struct packed {
        logic [CNT_W-1:0] reads_low_fail;
        logic [CNT_W-1:0] reads_mean_fail;
        logic [CNT_W-1:0] reads_n_fail;
        logic [CNT_W-1:0] reads_dropped;
        logic [CNT_W-1:0] reads_total;
        logic             low_rate_fail;
        logic             mean_quality_fail;
        logic             n_rate_fail;
        logic             dropped;
    } t_read_verdict;

    logic [sqrf_pkg::OFFSET_W-1:0] quality_offset;
    logic [sqrf_pkg::MIN_BQ_W-1:0] low_q_margin;
    logic [sqrf_pkg::RATE_W-1:0]   max_n_rate;
    logic [sqrf_pkg::MEAN_Q_W-1:0] min_mean_quality;
    logic [sqrf_pkg::RATE_W-1:0]   max_low_rate;

    logic [LEN_W-1:0]     read_length;
    logic [LEN_W-1:0]     unknown_bases;
    logic [LEN_W-1:0]     low_bases;
    logic [SUM_W-1:0]     quality_total;
    logic [CNT_W-1:0]     total_reads;
    logic [CNT_W-1:0]     dropped_reads;
    logic [CNT_W-1:0]     n_fail_reads;
    logic [CNT_W-1:0]     mean_fail_reads;
    logic [CNT_W-1:0]     low_fail_reads;

    t_read_verdict expected_verdicts[$];
    t_read_verdict oldest;
    t_read_verdict seen;

    task automatic restore_defaults();
        quality_offset   = sqrf_pkg::RST_QUALITY_OFFSET;
        low_q_margin     = sqrf_pkg::RST_LOW_Q_MARGIN;
        max_n_rate       = sqrf_pkg::RST_MAX_N_RATE;
        min_mean_quality = sqrf_pkg::RST_MIN_MEAN_QUALITY;
        max_low_rate     = sqrf_pkg::RST_MAX_LOW_RATE;
        read_length      = '0;
        unknown_bases    = '0;
        low_bases        = '0;
        quality_total    = '0;
        total_reads      = '0;
        dropped_reads    = '0;
        n_fail_reads     = '0;
        mean_fail_reads  = '0;
        low_fail_reads   = '0;
    endtask

    // Folds one base into the read statistics and, on the closing base,
    // works out the three rule verdicts by cross-multiplication.
    task automatic accumulate_base(input logic [CHR_W-1:0] base_char,
                                   input logic [CHR_W-1:0] quality_char,
                                   input logic             read_end);
        logic [63:0]   len;
        t_read_verdict verdict;
        // Bases beyond the maximum length are ignored, but still close the read.
        if (read_length < MAX_READ_LENGTH) begin
            read_length++;
            if (base_char == sqrf_pkg::UNKNOWN_BASE) begin
                unknown_bases++;
            end
            quality_total += quality_char;
            if ({1'b0, quality_char} < quality_offset + low_q_margin) begin
                low_bases++;
            end
        end
        if (read_end) begin
            len = 64'(read_length);
            verdict.n_rate_fail = (64'(unknown_bases) << 16) > 64'(max_n_rate) * len;
            verdict.mean_quality_fail = (64'(quality_total) << 8) <
                ((64'(quality_offset) << 8) + 64'(min_mean_quality)) * len;
            verdict.low_rate_fail = (64'(low_bases) << 16) > 64'(max_low_rate) * len;
            verdict.dropped = verdict.n_rate_fail || verdict.mean_quality_fail ||
                              verdict.low_rate_fail;
            total_reads++;
            if (verdict.dropped) dropped_reads++;
            if (verdict.n_rate_fail) n_fail_reads++;
            if (verdict.mean_quality_fail) mean_fail_reads++;
            if (verdict.low_rate_fail) low_fail_reads++;
            verdict.reads_total     = total_reads;
            verdict.reads_dropped   = dropped_reads;
            verdict.reads_n_fail    = n_fail_reads;
            verdict.reads_mean_fail = mean_fail_reads;
            verdict.reads_low_fail  = low_fail_reads;
            expected_verdicts.push_back(verdict);
            read_length   = '0;
            unknown_bases = '0;
            low_bases     = '0;
            quality_total = '0;
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] expected,
                               input logic [31:0] actual);
        if (expected !== actual) begin
            o_fail_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, field, expected, actual);
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_defaults();
            expected_verdicts.delete();
        end else begin
            if (i_verdict_tvalid && i_verdict_tready) begin
                seen = i_verdict_tdata[$bits(t_read_verdict)-1:0];
                if (expected_verdicts.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected result, expected none, actual %h",
                             $time, i_verdict_tdata);
                end else begin
                    oldest = expected_verdicts.pop_front();
                    check_field("dropped", 32'(oldest.dropped), 32'(seen.dropped));
                    check_field("n_rate_fail", 32'(oldest.n_rate_fail),
                                32'(seen.n_rate_fail));
                    check_field("mean_quality_fail", 32'(oldest.mean_quality_fail),
                                32'(seen.mean_quality_fail));
                    check_field("low_rate_fail", 32'(oldest.low_rate_fail),
                                32'(seen.low_rate_fail));
                    check_field("reads_total", oldest.reads_total, seen.reads_total);
                    check_field("reads_dropped", oldest.reads_dropped, seen.reads_dropped);
                    check_field("reads_n_fail", oldest.reads_n_fail, seen.reads_n_fail);
                    check_field("reads_mean_fail", oldest.reads_mean_fail,
                                seen.reads_mean_fail);
                    check_field("reads_low_fail", oldest.reads_low_fail,
                                seen.reads_low_fail);
                    check_field("padding", 32'd0,
                                32'(i_verdict_tdata[sqrf_pkg::OUT_TDATA_W-1:
                                                    $bits(t_read_verdict)]));
                end
            end
            if (i_cfg_we) begin
                case (sqrf_pkg::t_cfg_index'(i_cfg_index))
                    sqrf_pkg::CFG_QUALITY_OFFSET:
                        quality_offset = i_cfg_wdata[sqrf_pkg::OFFSET_W-1:0];
                    sqrf_pkg::CFG_LOW_Q_MARGIN:
                        low_q_margin = i_cfg_wdata[sqrf_pkg::MIN_BQ_W-1:0];
                    sqrf_pkg::CFG_MAX_N_RATE:
                        max_n_rate = i_cfg_wdata[sqrf_pkg::RATE_W-1:0];
                    sqrf_pkg::CFG_MIN_MEAN_QUALITY:
                        min_mean_quality = i_cfg_wdata[sqrf_pkg::MEAN_Q_W-1:0];
                    sqrf_pkg::CFG_MAX_LOW_RATE:
                        max_low_rate = i_cfg_wdata[sqrf_pkg::RATE_W-1:0];
                    default: ;
                endcase
            end
            if (i_base_tvalid && i_base_tready) begin
                accumulate_base(i_base_tdata[CHR_W-1:0], i_base_tdata[2*CHR_W-1:CHR_W],
                                i_base_tlast);
            end
        end
        o_pending = expected_verdicts.size();
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Read quality filter testbench
// Streams directed and random reads through the filter under several
// threshold settings, with random gaps on both streams, while a separate
// checker predicts and compares every result transfer.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CHR_W = sqrf_pkg::CHAR_W;

    // Clock limit of the whole run; the slowest correct run stays well under it.
    localparam int CLOCK_LIMIT   = 300000;
    // Random bases on top of the directed reads, shared out over the phases.
    localparam int RANDOM_BASES  = 245;
    localparam int RANDOM_PHASES = 7;
    // Extra settling time, in clocks, once every result has left.
    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_PERCENT  = 38;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [sqrf_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [sqrf_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [sqrf_pkg::IN_TDATA_W-1:0]  s_axis_tdata;   // base_char [7:0], quality_char [15:8]
    logic                             s_axis_tlast;   // read_end
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [sqrf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;   // verdict flags [3:0], counters [163:4]

    int pending_verdicts;
    int fail_count;
    int cycle_count;
    int bases_sent;
    int current_offset;
    // While set, neither stream idles nor stalls.
    logic steady_flow;

    sequence_read_quality_filter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    read_verdict_checker i_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_base_tvalid    (s_axis_tvalid),
        .i_base_tready    (s_axis_tready),
        .i_base_tdata     (s_axis_tdata),
        .i_base_tlast     (s_axis_tlast),
        .i_verdict_tvalid (m_axis_tvalid),
        .i_verdict_tready (m_axis_tready),
        .i_verdict_tdata  (m_axis_tdata),
        .o_pending        (pending_verdicts),
        .o_fail_count     (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CLOCK_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // The result side stalls at random, except during the steady stretch.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Offers one base and returns at the falling edge after its transfer, with
    // tvalid still high so that a following base goes out without a bubble.
    task automatic send_base(input logic [CHR_W-1:0] base_char,
                             input logic [CHR_W-1:0] quality_char,
                             input logic             read_end);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {quality_char, base_char};
        s_axis_tlast  <= read_end;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        bases_sent++;
        @(negedge i_clk);
    endtask

    // Holds the base stream back until every expected verdict has come out,
    // then lets the pipeline settle.
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_verdicts != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input sqrf_pkg::t_cfg_index index, input int value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_wdata <= sqrf_pkg::CFG_DATA_W'(value);
        @(negedge i_clk);
    endtask

    // Writes all five thresholds once the filter has gone quiet.
    task automatic program_thresholds(input int offset, input int min_quality,
                                      input int n_rate, input int mean_quality,
                                      input int low_rate);
        wait_for_drain();
        write_register(sqrf_pkg::CFG_QUALITY_OFFSET, offset);
        write_register(sqrf_pkg::CFG_LOW_Q_MARGIN, min_quality);
        write_register(sqrf_pkg::CFG_MAX_N_RATE, n_rate);
        write_register(sqrf_pkg::CFG_MIN_MEAN_QUALITY, mean_quality);
        write_register(sqrf_pkg::CFG_MAX_LOW_RATE, low_rate);
        i_cfg_we <= 1'b0;
        current_offset = offset;
    endtask

    // Picks a rate threshold: often a random fraction, sometimes the
    // extremes, including values above one which can never fail.
    function automatic int pick_rate();
        case ($urandom_range(0, 5))
            0:       return 0;
            1:       return 65536;
            2:       return $urandom_range(65537, 131071);
            default: return $urandom_range(1, 40000);
        endcase
    endfunction

    // A read of random length. Most qualities sit just above the current
    // offset so that the mean and low-quality rules land near their limits;
    // the rest span the whole character range.
    task automatic send_random_read();
        string nucleotides;
        int    length;
        int    n_percent;
        int    quality;
        logic [CHR_W-1:0] base_char;
        nucleotides = "ACGT";
        length = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 200)
                                              : $urandom_range(1, 16);
        case ($urandom_range(0, 3))
            0:       n_percent = 0;
            1:       n_percent = 5;
            2:       n_percent = 25;
            default: n_percent = 60;
        endcase
        for (int i = 0; i < length; i++) begin
            if ($urandom_range(0, 99) < n_percent) begin
                base_char = sqrf_pkg::UNKNOWN_BASE;
            end else if ($urandom_range(0, 3) == 0) begin
                base_char = CHR_W'($urandom_range(0, 255));
            end else begin
                base_char = nucleotides[$urandom_range(0, 3)];
            end
            if ($urandom_range(0, 4) == 0) begin
                quality = $urandom_range(0, 255);
            end else begin
                quality = current_offset + $urandom_range(0, 45);
                if (quality > 255) quality = 255;
            end
            send_base(base_char, CHR_W'(quality), i == length - 1);
        end
    endtask

    initial begin
        int phase_start;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tlast   = 1'b0;
        m_axis_tready  = 1'b0;
        steady_flow    = 1'b0;
        cycle_count    = 0;
        bases_sent     = 0;
        current_offset = sqrf_pkg::RST_QUALITY_OFFSET;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed reads under the reset thresholds: offset 33, low-quality
        // limit 38, N rate about a tenth, low rate one half, mean 33.
        send_base(sqrf_pkg::UNKNOWN_BASE, 8'd0, 1'b1);  // a lone N of quality zero fails all rules
        send_base(8'd255, 8'd255, 1'b1);        // top codes pass
        send_base(8'd0, 8'd38, 1'b1);           // quality at the low threshold is not low
        send_base(8'd65, 8'd37, 1'b1);          // just below it is low
        send_base(8'd71, 8'd33, 1'b1);          // mean exactly at its minimum still passes
        send_base(8'd84, 8'd10, 1'b1);          // quality below the offset
        // One N in ten bases sits just under the N rate limit.
        for (int i = 0; i < 9; i++) begin
            send_base("A", 8'd40, 1'b0);
        end
        send_base(sqrf_pkg::UNKNOWN_BASE, 8'd40, 1'b1);
        // One low base in two sits exactly on the low rate limit.
        send_base("C", 8'd60, 1'b0);
        send_base("G", 8'd37, 1'b1);

        // With both rate limits at zero, any N or low base that were counted
        // would drop this overlong read: its trailing bases must be ignored.
        // The whole read streams without idling on either side.
        program_thresholds(33, 5, 0, 0, 0);
        steady_flow = 1'b1;
        for (int i = 0; i < sqrf_pkg::MAX_READ_LENGTH_DEFAULT; i++) begin
            send_base("C", "I", 1'b0);
        end
        send_base(sqrf_pkg::UNKNOWN_BASE, 8'd0, 1'b0);
        send_base(sqrf_pkg::UNKNOWN_BASE, 8'd0, 1'b1);
        steady_flow = 1'b0;
        send_base(sqrf_pkg::UNKNOWN_BASE, "I", 1'b1);

        // Random reads, one threshold setting per phase.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: program_thresholds(0, 0, 0, 0, 0);
                1: program_thresholds(127, 127, 131071, 32767, 131071);
                2: program_thresholds(64, 0, 65536, $urandom_range(0, 16384), 65536);
                6: program_thresholds(sqrf_pkg::RST_QUALITY_OFFSET,
                                      sqrf_pkg::RST_LOW_Q_MARGIN,
                                      sqrf_pkg::RST_MAX_N_RATE,
                                      sqrf_pkg::RST_MIN_MEAN_QUALITY,
                                      sqrf_pkg::RST_MAX_LOW_RATE);
                default: program_thresholds($urandom_range(0, 1) ? 33 : $urandom_range(0, 127),
                                            $urandom_range(0, 40), pick_rate(),
                                            $urandom_range(0, 50 * 256), pick_rate());
            endcase
            steady_flow = (phase == 3);
            phase_start = bases_sent;
            while (bases_sent - phase_start < RANDOM_BASES / RANDOM_PHASES) begin
                send_random_read();
                // Mid-phase, hold the stream until the filter has emptied.
                if (phase == 4 && bases_sent - phase_start >= RANDOM_BASES / 14
                        && bases_sent - phase_start < RANDOM_BASES / 14 + 16) begin
                    wait_for_drain();
                end
            end
            steady_flow = 1'b0;
        end

        wait_for_drain();
        if (fail_count == 0 && pending_verdicts == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
